FILE: hdl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// shared types and constants of the line point generator
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_BITS = 6;
  localparam int FIELD_W    = 6;
  localparam int VALUE_W    = 8;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic load;
    logic step;
  } lpg_cmd_t;

  typedef struct packed {
    logic at_last;
  } lpg_status_t;

endpackage

FILE: hdl/lpg_ctrl.sv
// ----------------------------------------------------------------------------
// lpg_ctrl
// controller: takes a command word, then walks the line one point per word out
// ----------------------------------------------------------------------------
module lpg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  output logic                 pt_valid_o,
  input  logic                 pt_ready_i,
  input  lpg_pkg::lpg_status_t status_i,
  output lpg_pkg::lpg_cmd_t    cmd_o
);
  import lpg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (pt_ready_i) begin
          if (status_i.at_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign pt_valid_o  = (state_q == ST_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/lpg_dp.sv
// ----------------------------------------------------------------------------
// lpg_dp
// datapath: current point, error term, distances and step directions
// ----------------------------------------------------------------------------
module lpg_dp (
  input  logic                 clk_i,
  input  lpg_pkg::lpg_cmd_t    cmd_i,
  input  lpg_pkg::coord_t      start_row_i,
  input  lpg_pkg::coord_t      start_col_i,
  input  lpg_pkg::coord_t      end_row_i,
  input  lpg_pkg::coord_t      end_col_i,
  input  lpg_pkg::value_t      pixel_value_i,
  output lpg_pkg::coord_t      point_row_o,
  output lpg_pkg::coord_t      point_col_o,
  output lpg_pkg::value_t      point_value_o,
  output lpg_pkg::lpg_status_t status_o
);
  import lpg_pkg::*;

  coord_t row_q, col_q, end_row_q, end_col_q, dr_q, dc_q, cnt_q;
  value_t value_q;
  err_t   err_q;
  logic   rdir_q, cdir_q;

  coord_t dr_in, dc_in;
  err_t   e2, neg_dc, dr_ext, err_step;
  logic   move_r, move_c;

  always_comb begin
    dr_in    = (end_row_i >= start_row_i) ? coord_t'(end_row_i - start_row_i)
                                          : coord_t'(start_row_i - end_row_i);
    dc_in    = (end_col_i >= start_col_i) ? coord_t'(end_col_i - start_col_i)
                                          : coord_t'(start_col_i - end_col_i);
    e2       = err_q <<< 1;
    dr_ext   = err_t'({3'b000, dr_q});
    neg_dc   = -err_t'({3'b000, dc_q});
    move_r   = (e2 > neg_dc);
    move_c   = (e2 < dr_ext);
    err_step = err_q + (move_r ? neg_dc : err_t'(0)) + (move_c ? dr_ext : err_t'(0));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q     <= start_row_i;
      col_q     <= start_col_i;
      end_row_q <= end_row_i;
      end_col_q <= end_col_i;
      value_q   <= pixel_value_i;
      dr_q      <= dr_in;
      dc_q      <= dc_in;
      rdir_q    <= (start_row_i < end_row_i);
      cdir_q    <= (start_col_i < end_col_i);
      err_q     <= err_t'({3'b000, dr_in}) - err_t'({3'b000, dc_in});
      cnt_q     <= '0;
    end else if (cmd_i.step) begin
      if (move_r) begin
        row_q <= rdir_q ? coord_t'(row_q + 1'b1) : coord_t'(row_q - 1'b1);
      end
      if (move_c) begin
        col_q <= cdir_q ? coord_t'(col_q + 1'b1) : coord_t'(col_q - 1'b1);
      end
      err_q <= err_step;
      cnt_q <= coord_t'(cnt_q + 1'b1);
    end
  end

  // guard: the last word always carries the end point
  logic runaway;
  assign runaway          = (cnt_q == {COORD_BITS{1'b1}});
  assign status_o.at_last = ((row_q == end_row_q) && (col_q == end_col_q)) || runaway;
  assign point_row_o      = runaway ? end_row_q : row_q;
  assign point_col_o      = runaway ? end_col_q : col_q;
  assign point_value_o    = value_q;

endmodule

FILE: hdl/line_point_generator.sv
// ----------------------------------------------------------------------------
// line_point_generator
// integer error-term line walker: one command word in, one word per point out
// ----------------------------------------------------------------------------
// usage:
//   the slave channel takes a line command (two endpoints and a pixel value);
//   the master channel gives the points of the line in order from the first
//   endpoint to the second, tlast high on the final point.
//   a command word is taken only while the block is idle; the first point is
//   shown in the cycle after the command is taken.
//   a line of n points (n = max(|drow|, |dcol|) + 1, at most 64) leaves one point
//   a cycle when the receiver never stalls, set by the single step of the
//   error-term loop; the next command is taken in the cycle after the last
//   point leaves.
//   the point on the master channel is held in registers: when the receiver
//   stalls, the point holds and the walk pauses.
//   reset returns the block to idle with tready high and no point shown.
//   s_axis_tdata: start_row [5:0], start_col [11:6], end_row [17:12],
//   end_col [23:18], pixel_value [31:24]
//   m_axis_tdata: point_row [5:0], point_col [11:6], point_value [19:12]
// ----------------------------------------------------------------------------
module line_point_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_row, start_col, end_row, end_col, pixel_value
  input  logic [lpg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // point_row, point_col, point_value, zero fill
  output logic [lpg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import lpg_pkg::*;

  lpg_cmd_t    cmd;
  lpg_status_t status;
  coord_t      point_row, point_col;
  value_t      point_value;

  lpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .pt_valid_o  (m_axis_tvalid),
    .pt_ready_i  (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lpg_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .start_row_i   (s_axis_tdata[COORD_BITS-1:0]),
    .start_col_i   (s_axis_tdata[FIELD_W +: COORD_BITS]),
    .end_row_i     (s_axis_tdata[2*FIELD_W +: COORD_BITS]),
    .end_col_i     (s_axis_tdata[3*FIELD_W +: COORD_BITS]),
    .pixel_value_i (s_axis_tdata[4*FIELD_W +: VALUE_W]),
    .point_row_o   (point_row),
    .point_col_o   (point_col),
    .point_value_o (point_value),
    .status_o      (status)
  );

  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[COORD_BITS-1:0]          = point_row;
    m_axis_tdata[FIELD_W +: COORD_BITS]   = point_col;
    m_axis_tdata[2*FIELD_W +: VALUE_W]    = point_value;
  end
  assign m_axis_tlast = status.at_last;

  // never take a command while a point is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("command taken while a point is pending");

  // a taken command shows a point next cycle
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no point after command");

  // the walk goes on until the last point
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("walk stopped before last point");

  // after the last point the block is idle again
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after last point");

endmodule

FILE: dv/line_point_generator_checker.sv
// ----------------------------------------------------------------------------
// line_point_generator_checker
// watches the command and point channels, walks each accepted line with an
// integer error-term walk of its own and compares every point that leaves the
// block, field by field, with the oldest point still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_point_generator_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // start_row, start_col, end_row, end_col, pixel_value
  input  logic [lpg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // point_row, point_col, point_value, zero fill
  input  logic [lpg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast,
  output int                             fail_count_o,
  output int                             points_owed_o
);

  import lpg_pkg::*;

  typedef struct {
    coord_t row;
    coord_t col;
    value_t value;
    logic   last;
  } line_point_t;

  line_point_t owed_points[$];

  initial begin
    fail_count_o  = 0;
    points_owed_o = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // error-term walk from the first endpoint to the second
  function automatic void walk_line(input logic [IN_DATA_W-1:0] word);
    int r0, c0, r1, c1, dr, dc, rstep, cstep, err, e2, row, col, n;
    value_t value;
    line_point_t pt;
    r0    = int'(word[5:0]);
    c0    = int'(word[11:6]);
    r1    = int'(word[17:12]);
    c1    = int'(word[23:18]);
    value = word[31:24];
    dr    = (r1 >= r0) ? r1 - r0 : r0 - r1;
    dc    = (c1 >= c0) ? c1 - c0 : c0 - c1;
    rstep = (r0 < r1) ? 1 : -1;
    cstep = (c0 < c1) ? 1 : -1;
    err   = dr - dc;
    row   = r0;
    col   = c0;
    n     = 0;
    while ((row != r1 || col != c1) && n < (1 << COORD_BITS) - 1) begin
      e2        = 2 * err;
      pt.row    = coord_t'(row);
      pt.col    = coord_t'(col);
      pt.value  = value;
      pt.last   = 1'b0;
      owed_points.push_back(pt);
      n++;
      if (e2 > -dc) begin
        err -= dc;
        row += rstep;
      end
      if (e2 < dr) begin
        err += dr;
        col += cstep;
      end
    end
    pt.row   = coord_t'(r1);
    pt.col   = coord_t'(c1);
    pt.value = value;
    pt.last  = 1'b1;
    owed_points.push_back(pt);
  endfunction

  always @(posedge clk_i) begin
    line_point_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        walk_line(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_points.size() == 0) begin
          report_mismatch("surplus point", 1, 0);
        end else begin
          want = owed_points.pop_front();
          if (m_axis_tdata[5:0] !== want.row) begin
            report_mismatch("point_row", int'(m_axis_tdata[5:0]), int'(want.row));
          end
          if (m_axis_tdata[11:6] !== want.col) begin
            report_mismatch("point_col", int'(m_axis_tdata[11:6]), int'(want.col));
          end
          if (m_axis_tdata[19:12] !== want.value) begin
            report_mismatch("point_value", int'(m_axis_tdata[19:12]), int'(want.value));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch("last_point", int'(m_axis_tlast), int'(want.last));
          end
        end
      end
      points_owed_o = owed_points.size();
    end
  end

endmodule

FILE: dv/line_point_generator_tb.sv
// ----------------------------------------------------------------------------
// line_point_generator_tb
// drives directed and random line commands into the line point generator with
// random gaps on the command side and random stalls on the point side; the
// checker predicts and compares every point, this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_point_generator_tb;

  import lpg_pkg::*;

  localparam int NUM_RANDOM  = 430;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  int                    fail_count;
  int                    points_owed;
  int                    quiet_cycles;

  logic [IN_DATA_W-1:0]  line_cmds[$];

  line_point_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_point_generator_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .points_owed_o (points_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [IN_DATA_W-1:0] pack_cmd(input int r0, input int c0,
                                                    input int r1, input int c1,
                                                    input int value);
    return {value_t'(value), coord_t'(c1), coord_t'(r1), coord_t'(c0), coord_t'(r0)};
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > (1 << COORD_BITS) - 1) return (1 << COORD_BITS) - 1;
    return v;
  endfunction

  // mostly short or shaped lines, the rest anywhere on the grid
  function automatic logic [IN_DATA_W-1:0] random_cmd();
    int r0, c0, r1, c1, d, kind;
    r0   = $urandom_range(0, 63);
    c0   = $urandom_range(0, 63);
    r1   = $urandom_range(0, 63);
    c1   = $urandom_range(0, 63);
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
      end
      3, 4, 5: begin
        r1 = clamp_coord(r0 + $urandom_range(0, 8) - 4);
        c1 = clamp_coord(c0 + $urandom_range(0, 8) - 4);
      end
      6: begin
        if ($urandom_range(0, 1)) r1 = r0;
        else c1 = c0;
      end
      7: begin
        d  = $urandom_range(0, 63);
        r1 = clamp_coord($urandom_range(0, 1) ? r0 + d : r0 - d);
        c1 = clamp_coord($urandom_range(0, 1) ? c0 + d : c0 - d);
        d  = (r1 > r0 ? r1 - r0 : r0 - r1);
        if ((c1 > c0 ? c1 - c0 : c0 - c1) < d) d = (c1 > c0 ? c1 - c0 : c0 - c1);
        r1 = (r1 >= r0) ? r0 + d : r0 - d;
        c1 = (c1 >= c0) ? c0 + d : c0 - d;
      end
      default: begin
        r1 = r0;
        c1 = c0;
      end
    endcase
    return pack_cmd(r0, c0, r1, c1, $urandom_range(0, 255));
  endfunction

  function automatic int draw_gap(input int max_gap);
    return $urandom_range(0, max_gap);
  endfunction

  function automatic int pick_gap_mode();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      default: return 14;
    endcase
  endfunction

  // point side: random stalls before each word
  initial begin
    int w, max_gap, n_words;
    m_axis_tready = 1'b0;
    max_gap       = 14;
    n_words       = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (n_words % 150 == 0) max_gap = pick_gap_mode();
      w = draw_gap(max_gap);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      n_words++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // command side
  initial begin
    int w, max_gap, n_directed;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    quiet_cycles  = 0;

    line_cmds.push_back(pack_cmd(0, 0, 0, 0, 8'h00));
    line_cmds.push_back(pack_cmd(63, 63, 63, 63, 8'hff));
    line_cmds.push_back(pack_cmd(0, 0, 63, 63, 8'ha5));
    line_cmds.push_back(pack_cmd(63, 63, 0, 0, 8'h5a));
    line_cmds.push_back(pack_cmd(0, 0, 0, 63, 8'h01));
    line_cmds.push_back(pack_cmd(0, 63, 0, 0, 8'h80));
    line_cmds.push_back(pack_cmd(0, 0, 63, 0, 8'h7f));
    line_cmds.push_back(pack_cmd(63, 0, 0, 0, 8'hfe));
    line_cmds.push_back(pack_cmd(0, 63, 63, 0, 8'h33));
    line_cmds.push_back(pack_cmd(63, 0, 0, 63, 8'hcc));
    line_cmds.push_back(pack_cmd(10, 10, 13, 30, 8'h2a));
    line_cmds.push_back(pack_cmd(10, 10, 30, 13, 8'h2b));
    line_cmds.push_back(pack_cmd(30, 30, 27, 10, 8'h2c));
    line_cmds.push_back(pack_cmd(30, 30, 10, 27, 8'h2d));
    line_cmds.push_back(pack_cmd(5, 40, 9, 20, 8'h2e));
    line_cmds.push_back(pack_cmd(40, 5, 20, 9, 8'h2f));
    line_cmds.push_back(pack_cmd(20, 20, 21, 21, 8'h55));
    line_cmds.push_back(pack_cmd(20, 20, 21, 20, 8'haa));
    line_cmds.push_back(pack_cmd(20, 20, 20, 19, 8'h0f));
    line_cmds.push_back(pack_cmd(0, 0, 1, 63, 8'hf0));
    n_directed = line_cmds.size();
    repeat (NUM_RANDOM) line_cmds.push_back(random_cmd());

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    max_gap = 14;
    foreach (line_cmds[i]) begin
      if (i == n_directed || i == n_directed + 200) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (points_owed != 0);
      end
      if (i % 40 == 0) max_gap = pick_gap_mode();
      w = draw_gap(max_gap);
      if (w > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= line_cmds[i];
      do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    while (points_owed != 0) @(negedge clk_i);
    repeat (DRAIN_TAIL) @(negedge clk_i);

    if (fail_count == 0 && points_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: line_point_generator.f
hdl/lpg_pkg.sv
hdl/lpg_ctrl.sv
hdl/lpg_dp.sv
hdl/line_point_generator.sv
dv/line_point_generator_checker.sv
dv/line_point_generator_tb.sv
